@@ src/binary_to_decimal_ascii_unit_defines.svh @@
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_unit_defines
// assertion macros shared by the binary to decimal ascii unit
// ----------------------------------------------------------------------------
`ifndef BINARY_TO_DECIMAL_ASCII_UNIT_DEFINES_SVH
`define BINARY_TO_DECIMAL_ASCII_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define B2DA_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define B2DA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define B2DA_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define B2DA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

@@ src/b2da_pkg.sv @@
// ----------------------------------------------------------------------------
// b2da_pkg
// shared constants and types of the binary to decimal ascii unit
// ----------------------------------------------------------------------------
`default_nettype none

package b2da_pkg;

   localparam int VALUE_BITS = 32;
   localparam int REQ_BITS   = 32;
   // bits that actually take part in the conversion
   localparam int EFF_BITS   = (VALUE_BITS < REQ_BITS) ? VALUE_BITS : REQ_BITS;
   // decimal digits of 2^EFF_BITS - 1 (1233/4096 approximates log10 of 2)
   localparam int NUM_DIGITS = ((EFF_BITS * 1233) >> 12) + 1;
   localparam int BCD_BITS   = NUM_DIGITS * 4;
   localparam int BIT_CNT_W  = $clog2(EFF_BITS);
   localparam int DIG_CNT_W  = $clog2(NUM_DIGITS + 1);
   localparam int CHAR_BITS  = 6;

   localparam logic [CHAR_BITS-1:0] CHAR_ZERO = 6'd48;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SKIP,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic dabble;
      logic shift;
   } dp_cmd_type;

   typedef struct packed {
      logic top_zero;
   } dp_status_type;

endpackage

`default_nettype wire

@@ src/binary_to_decimal_ascii_unit.sv @@
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_unit
// unsigned binary to decimal ascii digits, most significant first
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. The value is run
// through a serial double dabble pass of one bit per cycle, the leading
// zero digits are then shifted out one per cycle, and the remaining digits
// leave one per cycle on rsp_strobe, the last one flagged by rsp_last;
// zero gives the single digit '0'. Digits cannot be held off: the receiver
// must take one every cycle that rsp_strobe is high. busy stays high after
// the accept until the last digit has left, so a new item is taken only
// once the conversion, the zero skip and the digit output are all done.
`default_nettype none

module binary_to_decimal_ascii_unit
   import b2da_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire logic [REQ_BITS-1:0]  req_value,
   output logic                      rsp_strobe,
   output logic [CHAR_BITS-1:0]      rsp_digit_char,
   output logic                      rsp_last
);

   dp_cmd_type    cmd;
   dp_status_type status;

   b2da_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .status     (status),
      .cmd        (cmd),
      .rsp_strobe (rsp_strobe),
      .rsp_last   (rsp_last)
   );

   b2da_dpath u_dpath (
      .clock          (clock),
      .req_value      (req_value),
      .cmd            (cmd),
      .status         (status),
      .rsp_digit_char (rsp_digit_char)
   );

endmodule

`default_nettype wire

@@ src/b2da_dpath.sv @@
// ----------------------------------------------------------------------------
// b2da_dpath
// double dabble shift register and digit output
// ----------------------------------------------------------------------------
`default_nettype none

module b2da_dpath
   import b2da_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic [REQ_BITS-1:0]  req_value,
   input  wire dp_cmd_type           cmd,
   output dp_status_type             status,
   output logic [CHAR_BITS-1:0]      rsp_digit_char
);

   logic [EFF_BITS-1:0] val_ff, val_in;
   logic [BCD_BITS-1:0] bcd_ff, bcd_in;
   logic [BCD_BITS-1:0] bcd_adj;
   logic [3:0]          top_digit;

   // add 3 to every digit of 5 or more before the shift
   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (bcd_ff[i*4 +: 4] >= 4'd5) begin
            bcd_adj[i*4 +: 4] = bcd_ff[i*4 +: 4] + 4'd3;
         end else begin
            bcd_adj[i*4 +: 4] = bcd_ff[i*4 +: 4];
         end
      end
   end

   always_comb begin
      val_in = val_ff;
      bcd_in = bcd_ff;
      priority if (cmd.load) begin
         val_in = req_value[EFF_BITS-1:0];
         bcd_in = '0;
      end else if (cmd.dabble) begin
         val_in = {val_ff[EFF_BITS-2:0], 1'b0};
         bcd_in = {bcd_adj[BCD_BITS-2:0], val_ff[EFF_BITS-1]};
      end else if (cmd.shift) begin
         bcd_in = {bcd_ff[BCD_BITS-5:0], 4'd0};
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
      bcd_ff <= bcd_in;
   end

   assign top_digit       = bcd_ff[BCD_BITS-1 -: 4];
   assign status.top_zero = (top_digit == 4'd0);
   assign rsp_digit_char  = CHAR_ZERO + {2'b00, top_digit};

endmodule

`default_nettype wire

@@ src/b2da_ctrl.sv @@
// ----------------------------------------------------------------------------
// b2da_ctrl
// sequencer: conversion passes, leading zero skip and digit emission
// ----------------------------------------------------------------------------
`default_nettype none

`include "binary_to_decimal_ascii_unit_defines.svh"

module b2da_ctrl
   import b2da_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire dp_status_type status,
   output dp_cmd_type   cmd,
   output logic         rsp_strobe,
   output logic         rsp_last
);

   state_type             state_ff, state_in;
   logic [BIT_CNT_W-1:0]  bit_cnt_ff, bit_cnt_in;
   logic [DIG_CNT_W-1:0]  dig_cnt_ff, dig_cnt_in;
   logic                  bits_done;
   logic                  one_left;

   assign bits_done = (bit_cnt_ff == '0);
   assign one_left  = (dig_cnt_ff == DIG_CNT_W'(1));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_CONVERT;
         end
         ST_CONVERT: begin
            if (bits_done) state_in = ST_SKIP;
         end
         ST_SKIP: begin
            if (!status.top_zero || one_left) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (one_left) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // counters
   always_comb begin
      bit_cnt_in = bit_cnt_ff;
      dig_cnt_in = dig_cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            bit_cnt_in = BIT_CNT_W'(EFF_BITS - 1);
         end
         ST_CONVERT: begin
            bit_cnt_in = bit_cnt_ff - BIT_CNT_W'(1);
            dig_cnt_in = DIG_CNT_W'(NUM_DIGITS);
         end
         ST_SKIP: begin
            if (status.top_zero && !one_left) dig_cnt_in = dig_cnt_ff - DIG_CNT_W'(1);
         end
         ST_EMIT: begin
            dig_cnt_in = dig_cnt_ff - DIG_CNT_W'(1);
         end
         default: ;
      endcase
   end

   // outputs
   always_comb begin
      cmd        = '0;
      busy       = 1'b1;
      rsp_strobe = 1'b0;
      rsp_last   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         ST_CONVERT: begin
            cmd.dabble = 1'b1;
         end
         ST_SKIP: begin
            cmd.shift = status.top_zero && !one_left;
         end
         ST_EMIT: begin
            cmd.shift  = 1'b1;
            rsp_strobe = 1'b1;
            rsp_last   = one_left;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         bit_cnt_ff <= '0;
         dig_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         bit_cnt_ff <= bit_cnt_in;
         dig_cnt_ff <= dig_cnt_in;
      end
   end

   `B2DA_ASSERT_NEXT(a_start_busy, clock, reset, start && !busy, busy, "accepted item did not raise busy")
   `B2DA_ASSERT_NEXT(a_last_idle, clock, reset, rsp_strobe && rsp_last, !busy, "busy held after last digit")
   `B2DA_ASSERT_NEXT(a_digits_back, clock, reset, rsp_strobe && !rsp_last, rsp_strobe, "gap inside digit burst")
   `B2DA_ASSERT_IMP(a_cnt_live, clock, reset, state_ff == ST_SKIP || state_ff == ST_EMIT, dig_cnt_ff != '0, "digit count ran out")

endmodule

`default_nettype wire
